// ===== rtl/avkf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avkf_pkg: shared types and constants
// Fixed-point widths, register indexes, opcodes, sequencer states, ALU operations and divider types.
// ----------------------------------------------------------------------------
package avkf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DT_BITS   = 16;
	localparam int W         = 32;
	localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;

	localparam logic [2:0] REG_Q_ALT     = 3'd0;
	localparam logic [2:0] REG_Q_VEL     = 3'd1;
	localparam logic [2:0] REG_Q_CROSS   = 3'd2;
	localparam logic [2:0] REG_R_MEAS    = 3'd3;
	localparam logic [2:0] REG_P_INITIAL = 3'd4;

	localparam logic OP_UPDATE  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// Shared unit operations.
	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MULFX,
		ALU_MULDT
	} alu_op_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRED,
		ST_DIV0,
		ST_DIV1,
		ST_CORR,
		ST_OUT
	} state_t;

	// Divider request and status.
	typedef struct packed {
		logic             start;
		logic signed [W-1:0] num;
		logic signed [W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic signed [W-1:0] quo;
		logic             clip;
	} div_rsp_t;

endpackage

// ===== rtl/avkf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avkf_in_if / avkf_out_if: valid-ready channels
// Input item and result item channels of the filter.
// ----------------------------------------------------------------------------
interface avkf_in_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic signed [31:0] measurement;
	logic [15:0]        time_step;
	modport source (output valid, opcode, measurement, time_step, input ready);
	modport sink (input valid, opcode, measurement, time_step, output ready);
endinterface

interface avkf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] altitude;
	logic signed [31:0] velocity;
	logic               fault;
	modport source (output valid, altitude, velocity, fault, input ready);
	modport sink (input valid, altitude, velocity, fault, output ready);
endinterface

// ===== rtl/altitude_velocity_kalman_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altitude_velocity_kalman_filter: two-state altitude/velocity Kalman filter
// Sequenced Q16.16 filter built around one shared saturating ALU and a
// radix-2 gain divider.
// ----------------------------------------------------------------------------
//  channel   dir  payload                          transfer when
//  in_ch     in   opcode, measurement, time_step   valid && ready
//  out_ch    out  altitude, velocity, fault        valid && ready
//  cfg       in   cfg_we, cfg_index, cfg_data      cfg_we high
//
// An update takes an accept step, 15 ALU steps for the prediction, two
// divider passes for the gains (a start, 48 quotient bits and a done each),
// 12 ALU steps for the correction and an output step. The divider works out
// one quotient bit per cycle. When the innovation variance is not positive
// the gains are cleared at once and the divider passes are skipped. A restart
// goes from the accept step straight to the output step. A finished result
// moves into the output register as soon as that register is free, and the
// next item may be accepted while it waits; the sequencer stalls in its output
// state only while the register still holds an untaken result. Reset loads
// the state and register defaults at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module altitude_velocity_kalman_filter
	import avkf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	avkf_in_if.sink     in_ch,
	avkf_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// Configuration registers.
	logic [30:0]         q_alt_q, q_vel_q, r_meas_q, p_init_q;
	logic signed [W-1:0] q_cross_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_alt_q   <= 31'd655;
			q_vel_q   <= 31'd6554;
			q_cross_q <= '0;
			r_meas_q  <= 31'd13107;
			p_init_q  <= 31'(ONE);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_Q_ALT:     q_alt_q   <= cfg_data[30:0];
				REG_Q_VEL:     q_vel_q   <= cfg_data[30:0];
				REG_Q_CROSS:   q_cross_q <= cfg_data;
				REG_R_MEAS:    r_meas_q  <= cfg_data[30:0];
				REG_P_INITIAL: p_init_q  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Register file of the sequencer. Slots 0-5 hold the filter state,
	// the rest hold intermediates of one update.
	localparam int NR = 16;
	localparam logic [3:0] R_ALT = 4'd0, R_VEL = 4'd1, R_PAA = 4'd2, R_PAV = 4'd3,
		R_PVA = 4'd4, R_PVV = 4'd5, R_T0 = 4'd6, R_VVDT = 4'd7, R_P00 = 4'd8,
		R_P01 = 4'd9, R_P10 = 4'd10, R_P11 = 4'd11, R_S = 4'd12, R_XP0 = 4'd13,
		R_K0 = 4'd14, R_K1 = 4'd15;
	// Extra operand sources addressed past the register file.
	localparam logic [4:0] X_DT = 5'd16, X_QA = 5'd17, X_QV = 5'd18, X_QC = 5'd19,
		X_RM = 5'd20, X_MEAS = 5'd21, X_ONE = 5'd22, X_Y = 5'd23;

	logic signed [W-1:0] rf_q [NR];
	logic signed [W-1:0] y_q;
	logic signed [W-1:0] meas_q;
	logic [15:0]         dt_q;
	logic                clip_q;
	logic                sfault_q;
	logic                restart_q;

	// Microprogram: op, destination, operand a, operand b.
	typedef struct packed {
		alu_op_t    op;
		logic [4:0] dst;
		logic [4:0] a;
		logic [4:0] b;
	} uop_t;

	localparam int NP = 15;
	localparam int NC = 12;

	function automatic uop_t pred_uop(input logic [3:0] i);
		uop_t u;
		u = '{ALU_ADD, 5'd0, 5'd0, 5'd0};
		unique case (i)
			4'd0:  u = '{ALU_MULDT, 5'(R_T0),   5'(R_VEL), X_DT};
			4'd1:  u = '{ALU_ADD,   5'(R_XP0),  5'(R_ALT), 5'(R_T0)};
			4'd2:  u = '{ALU_MULDT, 5'(R_VVDT), 5'(R_PVV), X_DT};
			4'd3:  u = '{ALU_ADD,   5'(R_T0),   5'(R_PVA), 5'(R_PAV)};
			4'd4:  u = '{ALU_MULDT, 5'(R_T0),   5'(R_T0),  X_DT};
			4'd5:  u = '{ALU_ADD,   5'(R_P00),  5'(R_PAA), 5'(R_T0)};
			4'd6:  u = '{ALU_MULDT, 5'(R_T0),   5'(R_VVDT), X_DT};
			4'd7:  u = '{ALU_ADD,   5'(R_P00),  5'(R_P00), 5'(R_T0)};
			4'd8:  u = '{ALU_ADD,   5'(R_P00),  5'(R_P00), X_QA};
			4'd9:  u = '{ALU_ADD,   5'(R_P01),  5'(R_PAV), 5'(R_VVDT)};
			4'd10: u = '{ALU_ADD,   5'(R_P01),  5'(R_P01), X_QC};
			4'd11: u = '{ALU_ADD,   5'(R_P10),  5'(R_PVA), 5'(R_VVDT)};
			4'd12: u = '{ALU_ADD,   5'(R_P10),  5'(R_P10), X_QC};
			4'd13: u = '{ALU_ADD,   5'(R_P11),  5'(R_PVV), X_QV};
			4'd14: u = '{ALU_ADD,   5'(R_S),    5'(R_P00), X_RM};
			default: ;
		endcase
		return u;
	endfunction

	function automatic uop_t corr_uop(input logic [3:0] i);
		uop_t u;
		u = '{ALU_ADD, 5'd0, 5'd0, 5'd0};
		unique case (i)
			4'd0:  u = '{ALU_SUB,   X_Y,        X_MEAS,    5'(R_XP0)};
			4'd1:  u = '{ALU_MULFX, 5'(R_T0),   5'(R_K0),  X_Y};
			4'd2:  u = '{ALU_ADD,   5'(R_ALT),  5'(R_XP0), 5'(R_T0)};
			4'd3:  u = '{ALU_MULFX, 5'(R_T0),   5'(R_K1),  X_Y};
			4'd4:  u = '{ALU_ADD,   5'(R_VEL),  5'(R_VEL), 5'(R_T0)};
			4'd5:  u = '{ALU_SUB,   5'(R_K0),   X_ONE,     5'(R_K0)};
			4'd6:  u = '{ALU_MULFX, 5'(R_PAA),  5'(R_K0),  5'(R_P00)};
			4'd7:  u = '{ALU_MULFX, 5'(R_PAV),  5'(R_K0),  5'(R_P01)};
			4'd8:  u = '{ALU_MULFX, 5'(R_T0),   5'(R_K1),  5'(R_P00)};
			4'd9:  u = '{ALU_SUB,   5'(R_PVA),  5'(R_P10), 5'(R_T0)};
			4'd10: u = '{ALU_MULFX, 5'(R_T0),   5'(R_K1),  5'(R_P01)};
			4'd11: u = '{ALU_SUB,   5'(R_PVV),  5'(R_P11), 5'(R_T0)};
			default: ;
		endcase
		return u;
	endfunction

	state_t     state_q, state_d;
	logic [3:0] step_q;
	uop_t       uop;
	logic       pred_last, corr_last;
	logic       alu_en;

	alu_op_t             alu_op;
	logic signed [W-1:0] alu_a, alu_b, alu_y;
	logic                alu_clip;

	div_req_t div_req;
	div_rsp_t div_rsp;

	function automatic logic signed [W-1:0] src(input logic [4:0] s,
		input logic signed [W-1:0] rf [NR], input logic [15:0] dt,
		input logic [30:0] qa, input logic [30:0] qv, input logic signed [W-1:0] qc,
		input logic [30:0] rm, input logic signed [W-1:0] ms,
		input logic signed [W-1:0] yv);
		logic signed [W-1:0] v;
		v = rf[s[3:0]];
		if (s[4]) begin
			unique case (s)
				X_DT:    v = {16'd0, dt};
				X_QA:    v = {1'b0, qa};
				X_QV:    v = {1'b0, qv};
				X_QC:    v = qc;
				X_RM:    v = {1'b0, rm};
				X_MEAS:  v = ms;
				X_ONE:   v = ONE;
				X_Y:     v = yv;
				default: v = '0;
			endcase
		end
		return v;
	endfunction

	always_comb begin
		uop       = (state_q == ST_CORR) ? corr_uop(step_q) : pred_uop(step_q);
		pred_last = (step_q == 4'(NP - 1));
		corr_last = (step_q == 4'(NC - 1));
		alu_en    = (state_q == ST_PRED) || (state_q == ST_CORR);
		alu_op    = uop.op;
		alu_a     = src(uop.a, rf_q, dt_q, q_alt_q, q_vel_q, q_cross_q, r_meas_q,
			meas_q, y_q);
		alu_b     = src(uop.b, rf_q, dt_q, q_alt_q, q_vel_q, q_cross_q, r_meas_q,
			meas_q, y_q);
	end

	avkf_alu u_alu (
		.op   (alu_op),
		.a    (alu_a),
		.b    (alu_b),
		.y    (alu_y),
		.clip (alu_clip)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_ch.valid)
				state_d = (in_ch.opcode == OP_RESTART) ? ST_OUT : ST_PRED;
			ST_PRED: if (pred_last) state_d = ST_DIV0;
			ST_DIV0: if (sfault_q || div_rsp.done)
				state_d = sfault_q ? ST_CORR : ST_DIV1;
			ST_DIV1: if (div_rsp.done) state_d = ST_CORR;
			ST_CORR: if (corr_last) state_d = ST_OUT;
			ST_OUT:  if (!out_ch.valid || out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Divider start pulses: first gain on entry to DIV0, second on entry to DIV1.
	// No division is started when the innovation variance is not positive.
	logic div_go_q;
	always_comb begin
		in_ch.ready   = (state_q == ST_IDLE);
		div_req.start = div_go_q;
		div_req.num   = (state_q == ST_DIV1) ? rf_q[R_P10] : rf_q[R_P00];
		div_req.den   = rf_q[R_S];
	end

	logic out_valid_q;
	logic signed [W-1:0] out_alt_q, out_vel_q;
	logic out_fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NR; i++)
				rf_q[i] <= (i == int'(R_PAA) || i == int'(R_PVV)) ? ONE : '0;
		end else begin
			state_q  <= state_d;
			div_go_q <= (state_q == ST_PRED && pred_last && alu_y > 0) ||
				(state_q == ST_DIV0 && div_rsp.done);
			if (state_q == ST_OUT && state_d == ST_IDLE) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			if (state_q != state_d) step_q <= '0;
			else if (alu_en) step_q <= step_q + 1'b1;
			if (in_ch.valid && in_ch.ready && in_ch.opcode == OP_RESTART) begin
				rf_q[R_ALT] <= in_ch.measurement;
				rf_q[R_VEL] <= '0;
				rf_q[R_PAA] <= {1'b0, p_init_q};
				rf_q[R_PAV] <= '0;
				rf_q[R_PVA] <= '0;
				rf_q[R_PVV] <= {1'b0, p_init_q};
			end else if (alu_en && !uop.dst[4]) begin
				rf_q[uop.dst[3:0]] <= alu_y;
			end else if (state_q == ST_DIV0 && sfault_q) begin
				rf_q[R_K0] <= '0;
				rf_q[R_K1] <= '0;
			end else if (div_rsp.done) begin
				if (state_q == ST_DIV0) rf_q[R_K0] <= div_rsp.quo;
				else rf_q[R_K1] <= div_rsp.quo;
			end
		end
	end

	// Intermediate registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			meas_q    <= in_ch.measurement;
			dt_q      <= in_ch.time_step;
			clip_q    <= 1'b0;
			restart_q <= (in_ch.opcode == OP_RESTART);
		end else if (alu_en) begin
			if (uop.dst == X_Y) y_q <= alu_y;
			if (alu_clip) clip_q <= 1'b1;
		end else if (div_rsp.done && div_rsp.clip) begin
			clip_q <= 1'b1;
		end
		if (state_q == ST_PRED && pred_last) sfault_q <= (alu_y <= 0);
		if (state_q == ST_OUT && state_d == ST_IDLE) begin
			out_alt_q   <= rf_q[R_ALT];
			out_vel_q   <= rf_q[R_VEL];
			out_fault_q <= !restart_q && (clip_q || sfault_q);
		end
	end

	avkf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		out_ch.valid    = out_valid_q;
		out_ch.altitude = out_alt_q;
		out_ch.velocity = out_vel_q;
		out_ch.fault    = out_fault_q;
	end

	// No input transfer while a computation is in flight.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	// The divider only finishes inside a gain state.
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV0 || state_q == ST_DIV1))
		else $error("divider done outside gain state");
	// A result is never overwritten before its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result lost");

endmodule

// ===== rtl/avkf_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avkf_alu: shared saturating arithmetic unit
// One saturating add, subtract or fixed-point multiply per cycle.
// ----------------------------------------------------------------------------
module avkf_alu
	import avkf_pkg::*;
(
	input  alu_op_t             op,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic signed [W-1:0] y,
	output logic                clip
);

	logic signed [2*W-1:0] prod;
	logic signed [2*W-1:0] wide;
	logic signed [W:0]     bm;

	always_comb begin
		// The time step is an unsigned 16-bit fraction; other operands are signed.
		bm   = (op == ALU_MULDT) ? {{(W-15){1'b0}}, b[15:0]} : {b[W-1], b};
		prod = a * bm;
		unique case (op)
			ALU_ADD:   wide = 64'(a) + 64'(b);
			ALU_SUB:   wide = 64'(a) - 64'(b);
			ALU_MULFX: wide = prod >>> FRAC_BITS;
			ALU_MULDT: wide = prod >>> DT_BITS;
			default:   wide = '0;
		endcase
		clip = 1'b0;
		if (wide > 64'sh7FFFFFFF) begin
			y = 32'sh7FFFFFFF;
			clip = 1'b1;
		end else if (wide < -64'sh80000000) begin
			y = 32'sh80000000;
			clip = 1'b1;
		end else begin
			y = wide[W-1:0];
		end
	end

endmodule

// ===== rtl/avkf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avkf_div: gain divider
// Computes (num * ONE) / den, den > 0, one quotient bit per cycle, truncated
// toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module avkf_div
	import avkf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int NW = W + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [NW-1:0] dvd_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  den_q;
	logic          neg_q;
	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic [W-1:0]  mag;
	logic [NW-1:0] num_ext;

	always_comb begin
		trial   = {rem_q[W-1:0], dvd_q[NW-1]};
		diff    = trial - {1'b0, den_q};
		mag     = req.num[W-1] ? W'(-req.num) : W'(req.num);
		num_ext = {mag, {FRAC_BITS{1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= num_ext;
			rem_q <= '0;
			quo_q <= '0;
			den_q <= req.den;
			neg_q <= req.num[W-1];
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (!diff[W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// The magnitude quotient is below 2^48; apply sign and saturate.
	logic [NW:0] qs;
	always_comb begin
		qs       = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
		rsp.done = done_q;
		rsp.clip = 1'b0;
		rsp.quo  = qs[W-1:0];
		if (!neg_q && quo_q > NW'(32'h7FFFFFFF)) begin
			rsp.quo  = 32'sh7FFFFFFF;
			rsp.clip = 1'b1;
		end else if (neg_q && quo_q > NW'(33'h80000000)) begin
			rsp.quo  = 32'sh80000000;
			rsp.clip = 1'b1;
		end
	end

endmodule

// ===== bench/altitude_velocity_kalman_filter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altitude_velocity_kalman_filter_test: self-checking bench for the filter
// A short table of directed items is followed by random phases, each under
// its own noise settings. Each result is checked against the row's fixed
// expected result or a bit-exact fixed-point copy of the filter in the bench.
// ----------------------------------------------------------------------------
module altitude_velocity_kalman_filter_test;
	import avkf_pkg::*;

	localparam int HALF_PERIOD   = 4;
	localparam int STALL_LIMIT   = 20000;
	localparam int ITEMS_PER_RUN = 170;
	localparam int NUM_PHASES    = 6;
	localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S_MIN = 32'sh80000000;

	typedef struct {
		logic               op;
		logic signed [31:0] meas;
		logic [15:0]        dt;
	} sample_t;

	typedef struct {
		logic signed [31:0] alt;
		logic signed [31:0] vel;
		logic               fault;
	} estimate_t;

	// A directed row carries the expected result when `fixed` is set. When
	// `zero_noise` is set, every noise register and p_initial is cleared first.
	typedef struct {
		logic               op;
		logic signed [31:0] meas;
		logic [15:0]        dt;
		bit                 fixed;
		logic signed [31:0] alt;
		logic signed [31:0] vel;
		logic               fault;
		bit                 zero_noise;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	avkf_in_if  in_ch();
	avkf_out_if out_ch();

	altitude_velocity_kalman_filter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Shadow copy of the filter's registers and state.
	logic [30:0]        noise_alt, noise_vel, meas_noise, cov_restart;
	logic signed [31:0] noise_cross;
	logic signed [31:0] est_alt, est_vel, p_aa, p_av, p_va, p_vv;
	bit                 clipped;

	estimate_t estimates_due[$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	bit        calm = 1'b0;

	// Saturate to signed 32 bits and remember that a clip happened.
	function automatic logic signed [31:0] sat(longint v);
		if (v > longint'(S_MAX)) begin
			clipped = 1'b1;
			return S_MAX;
		end
		if (v < longint'(S_MIN)) begin
			clipped = 1'b1;
			return S_MIN;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] add_sat(logic signed [31:0] a, logic signed [31:0] b);
		return sat(longint'(a) + longint'(b));
	endfunction

	function automatic logic signed [31:0] sub_sat(logic signed [31:0] a, logic signed [31:0] b);
		return sat(longint'(a) - longint'(b));
	endfunction

	// Arithmetic right shift on a signed 64-bit value rounds toward minus infinity.
	function automatic logic signed [31:0] mul_q(logic signed [31:0] a, logic signed [31:0] b);
		return sat((longint'(a) * longint'(b)) >>> FRAC_BITS);
	endfunction

	function automatic logic signed [31:0] mul_step(logic signed [31:0] a, logic [15:0] dt);
		longint d;
		d = longint'({16'd0, dt});
		return sat((longint'(a) * d) >>> DT_BITS);
	endfunction

	// Runs one item through the shadow filter and returns the expected result.
	function automatic estimate_t filter_step(sample_t s);
		estimate_t r;
		logic signed [31:0] xp0, xp1, vv_dt, pp00, pp01, pp10, pp11, innov_var;
		logic signed [31:0] k0, k1, y, omk;
		clipped = 1'b0;
		r.fault = 1'b0;
		if (s.op == OP_RESTART) begin
			est_alt = s.meas;
			est_vel = '0;
			p_aa = {1'b0, cov_restart};
			p_av = '0;
			p_va = '0;
			p_vv = {1'b0, cov_restart};
		end else begin
			xp0 = add_sat(est_alt, mul_step(est_vel, s.dt));
			xp1 = est_vel;
			vv_dt = mul_step(p_vv, s.dt);
			pp00 = add_sat(add_sat(add_sat(p_aa, mul_step(add_sat(p_va, p_av), s.dt)),
				mul_step(vv_dt, s.dt)), {1'b0, noise_alt});
			pp01 = add_sat(add_sat(p_av, vv_dt), noise_cross);
			pp10 = add_sat(add_sat(p_va, vv_dt), noise_cross);
			pp11 = add_sat(p_vv, {1'b0, noise_vel});
			innov_var = add_sat(pp00, {1'b0, meas_noise});
			k0 = '0;
			k1 = '0;
			// A non-positive innovation variance leaves both gains at zero.
			if (innov_var <= 0) begin
				r.fault = 1'b1;
			end else begin
				k0 = sat((longint'(pp00) * longint'(ONE)) / longint'(innov_var));
				k1 = sat((longint'(pp10) * longint'(ONE)) / longint'(innov_var));
			end
			y = sub_sat(s.meas, xp0);
			est_alt = add_sat(xp0, mul_q(k0, y));
			est_vel = add_sat(xp1, mul_q(k1, y));
			omk = sat(longint'(ONE) - longint'(k0));
			p_aa = mul_q(omk, pp00);
			p_av = mul_q(omk, pp01);
			p_va = sub_sat(pp10, mul_q(k1, pp00));
			p_vv = sub_sat(pp11, mul_q(k1, pp01));
			if (clipped)
				r.fault = 1'b1;
		end
		r.alt = est_alt;
		r.vel = est_vel;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Register write, only ever issued while the filter is idle. Drops the
	// write enable again before it returns.
	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_Q_ALT:     noise_alt = data[30:0];
			REG_Q_VEL:     noise_vel = data[30:0];
			REG_Q_CROSS:   noise_cross = data;
			REG_R_MEAS:    meas_noise = data[30:0];
			REG_P_INITIAL: cov_restart = data[30:0];
			default: ;
		endcase
	endtask

	// Waits until every expected result has come back, plus a margin.
	// Called at a falling edge and returns at one.
	task automatic drain;
		while (estimates_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Presents one item, with random idle cycles before it outside the calm stretch, until its transfer.
	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send(sample_t s, bit fixed, estimate_t fixed_res);
		estimate_t r;
		while (!calm && $urandom_range(99) < 12) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= s.op;
		in_ch.measurement <= s.meas;
		in_ch.time_step <= s.dt;
		do
			@(posedge clk);
		while (!in_ch.ready);
		r = filter_step(s);
		estimates_due.push_back(fixed ? fixed_res : r);
		@(negedge clk);
	endtask

	function automatic sample_t random_sample();
		sample_t s;
		int pick;
		s.op = ($urandom_range(99) < 10) ? OP_RESTART : OP_UPDATE;
		pick = $urandom_range(3);
		// Half the measurements lie near the current estimate so the filter tracks.
		if (pick < 2)
			s.meas = est_alt + $signed($urandom_range(8191)) * 32 - 32'sd131072;
		else if (pick == 2)
			s.meas = $urandom;
		else
			s.meas = $signed($urandom_range(65535)) - 32'sd32768;
		pick = $urandom_range(9);
		if (pick < 6)
			s.dt = 16'($urandom_range(16'h2000));
		else if (pick < 9)
			s.dt = 16'($urandom);
		else
			s.dt = $urandom_range(1) ? 16'hffff : 16'h0000;
		return s;
	endfunction

	// Receiver side: random back-pressure except during the calm stretch.
	always @(negedge clk) begin
		if (arst_n)
			out_ch.ready <= calm || ($urandom_range(99) >= 12);
	end

	// Result checker: every transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		estimate_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (estimates_due.size() == 0) begin
				report("unexpected result", out_ch.altitude, 32'h0);
			end else begin
				want = estimates_due.pop_front();
				if (out_ch.altitude !== want.alt)
					report("altitude", out_ch.altitude, want.alt);
				if (out_ch.velocity !== want.vel)
					report("velocity", out_ch.velocity, want.vel);
				if (out_ch.fault !== want.fault)
					report("fault", {31'd0, out_ch.fault}, {31'd0, want.fault});
			end
		end
	end

	// Watchdog: counts cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL altitude_velocity_kalman_filter");
			$finish;
		end
	end

	row_t directed_rows [15];

	initial begin
		sample_t   s;
		estimate_t fixed_res;
		int        sent;

		in_ch.valid = 1'b0;
		in_ch.opcode = OP_UPDATE;
		in_ch.measurement = '0;
		in_ch.time_step = '0;
		out_ch.ready = 1'b0;

		// Shadow of the reset values.
		noise_alt = 31'd655;
		noise_vel = 31'd6554;
		noise_cross = '0;
		meas_noise = 31'd13107;
		cov_restart = 31'd65536;
		est_alt = '0;
		est_vel = '0;
		p_aa = ONE;
		p_av = '0;
		p_va = '0;
		p_vv = ONE;

		// Restarts read back at a glance; the last two updates hit a zero
		// innovation variance and must come out as the prediction with a fault.
		directed_rows = '{
			'{OP_RESTART, S_MAX, 16'h0000, 1, S_MAX, 32'sd0, 1'b0, 0},
			'{OP_UPDATE, S_MAX, 16'h0000, 0, 0, 0, 0, 0},
			'{OP_UPDATE, S_MIN, 16'hffff, 0, 0, 0, 0, 0},
			'{OP_RESTART, S_MIN, 16'h0000, 1, S_MIN, 32'sd0, 1'b0, 0},
			'{OP_UPDATE, S_MAX, 16'hffff, 0, 0, 0, 0, 0},
			'{OP_RESTART, 32'sd0, 16'hffff, 1, 32'sd0, 32'sd0, 1'b0, 0},
			'{OP_UPDATE, 32'sd0, 16'h0000, 0, 0, 0, 0, 0},
			'{OP_UPDATE, 32'sh00010000, 16'h8000, 0, 0, 0, 0, 0},
			'{OP_UPDATE, -32'sh00010000, 16'h0001, 0, 0, 0, 0, 0},
			'{OP_RESTART, 32'sh00050000, 16'h0a3d, 1, 32'sh00050000, 32'sd0, 1'b0, 0},
			'{OP_UPDATE, 32'sh00058000, 16'h0a3d, 0, 0, 0, 0, 0},
			'{OP_UPDATE, 32'sh0005c000, 16'h0a3d, 0, 0, 0, 0, 0},
			'{OP_RESTART, 32'sd0, 16'h0000, 1, 32'sd0, 32'sd0, 1'b0, 1},
			'{OP_UPDATE, 32'sh00001234, 16'h0000, 1, 32'sd0, 32'sd0, 1'b1, 0},
			'{OP_UPDATE, -32'sd5, 16'hffff, 1, 32'sd0, 32'sd0, 1'b1, 0}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].zero_noise) begin
				in_ch.valid <= 1'b0;
				drain();
				write_reg(REG_Q_ALT, 32'h8000_0000);
				write_reg(REG_Q_VEL, 32'h0);
				write_reg(REG_Q_CROSS, 32'h0);
				write_reg(REG_R_MEAS, 32'h8000_0000);
				write_reg(REG_P_INITIAL, 32'h0);
			end
			s.op = directed_rows[i].op;
			s.meas = directed_rows[i].meas;
			s.dt = directed_rows[i].dt;
			fixed_res.alt = directed_rows[i].alt;
			fixed_res.vel = directed_rows[i].vel;
			fixed_res.fault = directed_rows[i].fault;
			send(s, directed_rows[i].fixed, fixed_res);
		end

		// Random phases, each under its own register settings, written idle.
		sent = 0;
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			in_ch.valid <= 1'b0;
			drain();
			case (phase)
				0: begin
					write_reg(REG_Q_ALT, 32'd655);
					write_reg(REG_Q_VEL, 32'd6554);
					write_reg(REG_Q_CROSS, 32'd0);
					write_reg(REG_R_MEAS, 32'd13107);
					write_reg(REG_P_INITIAL, 32'd65536);
				end
				1: begin
					// Largest noise everywhere, most negative cross term.
					write_reg(REG_Q_ALT, 32'h7fffffff);
					write_reg(REG_Q_VEL, 32'hffffffff);
					write_reg(REG_Q_CROSS, 32'h80000000);
					write_reg(REG_R_MEAS, 32'h7fffffff);
					write_reg(REG_P_INITIAL, 32'h7fffffff);
				end
				2: begin
					write_reg(REG_Q_ALT, 32'd0);
					write_reg(REG_Q_VEL, 32'd0);
					write_reg(REG_Q_CROSS, 32'h7fffffff);
					write_reg(REG_R_MEAS, 32'd0);
					write_reg(REG_P_INITIAL, 32'd0);
				end
				default: begin
					write_reg(REG_Q_ALT, $urandom_range(32'h0004_0000));
					write_reg(REG_Q_VEL, $urandom_range(32'h0004_0000));
					write_reg(REG_Q_CROSS, $urandom_range(32'h0002_0000) - 32'h0001_0000);
					write_reg(REG_R_MEAS, $urandom_range(32'h0008_0000));
					write_reg(REG_P_INITIAL, $urandom);
				end
			endcase
			for (int n = 0; n < ITEMS_PER_RUN; n++) begin
				// One long stretch in which neither side idles.
				calm = (sent >= 300 && sent < 450);
				// Once, hold the sender back until every result is in.
				if (sent == 600) begin
					in_ch.valid <= 1'b0;
					drain();
				end
				send(random_sample(), 0, fixed_res);
				sent++;
			end
		end
		calm = 1'b0;
		in_ch.valid <= 1'b0;
		drain();
		repeat (200) @(posedge clk);

		if (mismatches == 0 && estimates_due.size() == 0) begin
			$display("PASS altitude_velocity_kalman_filter");
		end else begin
			$display("FAIL altitude_velocity_kalman_filter");
		end
		$finish;
	end

endmodule

// ===== altitude_velocity_kalman_filter.f =====
rtl/avkf_pkg.sv
rtl/avkf_if.sv
rtl/avkf_alu.sv
rtl/avkf_div.sv
rtl/altitude_velocity_kalman_filter.sv
bench/altitude_velocity_kalman_filter_test.sv
